>>> rtl/mvfs_pkg.sv
// Shared types and constants for the MPEG video frame splitter.
package mvfs_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;

    localparam logic [15:0] PERIOD_RESET = 16'd3003;

    localparam logic [23:0] START_PREFIX = 24'h000001;
    localparam logic [7:0]  CODE_PICTURE = 8'h00;
    localparam logic [7:0]  CODE_USER    = 8'hB2;
    localparam logic [7:0]  CODE_SEQ     = 8'hB3;
    localparam logic [7:0]  CODE_EXT     = 8'hB5;
    localparam logic [7:0]  CODE_GOP     = 8'hB8;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [31:0] unit_start;
        logic [31:0] unit_length;
        logic [31:0] unit_number;
        logic [47:0] unit_time;
        logic        final_unit;
        logic        length_overflow;
    } t_unit;

    // Up to two result beats handed from the scanner to the result queue.
    typedef struct packed {
        logic [1:0] count;
        t_unit      first;
        t_unit      second;
    } t_push;

endpackage

>>> rtl/mvfs_scan.sv
// Input register, start code scan and frame bookkeeping.
module mvfs_scan #(
    parameter int OFFSET_BITS = mvfs_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_byte_value,
    input  logic                 i_end_of_stream,
    input  logic [15:0]          i_period,
    input  logic [1:0]           i_free,
    output mvfs_pkg::t_push      o_push
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic                   r_in_valid;
    logic [7:0]             r_byte;
    logic                   r_last;

    logic [23:0]            r_recent,     n_recent;
    logic [OFFSET_BITS-1:0] r_pos,        n_pos;
    logic                   r_open,       n_open;
    logic [OFFSET_BITS-1:0] r_start,      n_start;
    logic                   r_pfx_seen,   n_pfx_seen;
    logic [OFFSET_BITS-1:0] r_pfx_start,  n_pfx_start;
    logic [31:0]            r_count,      n_count;
    logic                   r_ovf,        n_ovf;

    logic                   advance;
    logic                   ovf_now;
    logic                   hit;
    logic [OFFSET_BITS-1:0] code_at;
    logic [OFFSET_BITS-1:0] start_next;
    logic [OFFSET_BITS-1:0] size;
    logic                   emit0;
    logic                   emit1;
    logic                   fallback;
    logic                   nf_open;
    logic [OFFSET_BITS-1:0] nf_start;
    logic [31:0]            nf_count;
    logic [1:0]             n_results;
    logic [47:0]            time_old;
    logic [47:0]            time_new;
    logic [63:0]            w_off0, w_len0, w_off1, w_len1, w_size;
    mvfs_pkg::t_unit        unit0, unit1;

    assign time_old = 48'(r_count) * 48'(i_period);
    assign time_new = 48'(nf_count) * 48'(i_period);

    always_comb begin
        ovf_now    = r_ovf | (r_pos == POS_MAX);
        hit        = (r_pos >= OFFSET_BITS'(3)) && (r_recent == mvfs_pkg::START_PREFIX);
        code_at    = r_pos - OFFSET_BITS'(3);
        start_next = r_pfx_seen ? r_pfx_start : code_at;
        size       = (r_pos == POS_MAX) ? POS_MAX : r_pos + OFFSET_BITS'(1);

        emit0       = 1'b0;
        nf_open     = r_open;
        nf_start    = r_start;
        nf_count    = r_count;
        n_pfx_seen  = r_pfx_seen;
        n_pfx_start = r_pfx_start;

        if (hit && r_byte == mvfs_pkg::CODE_PICTURE) begin
            emit0      = r_open && (start_next > r_start);
            nf_start   = start_next;
            nf_open    = 1'b1;
            n_pfx_seen = 1'b0;
            if (emit0) begin
                nf_count = r_count + 32'd1;
            end
        end else if (hit && !r_pfx_seen && (r_byte inside {mvfs_pkg::CODE_USER,
                     mvfs_pkg::CODE_SEQ, mvfs_pkg::CODE_EXT, mvfs_pkg::CODE_GOP})) begin
            n_pfx_seen  = 1'b1;
            n_pfx_start = code_at;
        end

        emit1    = r_last && nf_open && (nf_start < size);
        fallback = r_last && !emit1 && !emit0 && (nf_count == 32'd0);
        n_results = {1'b0, emit0} + {1'b0, emit1 | fallback};

        // Offsets and lengths are reported modulo 2^32.
        w_off0 = 64'(r_start);
        w_len0 = 64'(start_next - r_start);
        w_off1 = 64'(nf_start);
        w_len1 = 64'(size - nf_start);
        w_size = 64'(size);

        unit0.unit_start      = w_off0[31:0];
        unit0.unit_length     = w_len0[31:0];
        unit0.unit_number     = r_count;
        unit0.unit_time       = time_old;
        unit0.final_unit      = 1'b0;
        unit0.length_overflow = ovf_now;

        if (emit1) begin
            unit1.unit_start  = w_off1[31:0];
            unit1.unit_length = w_len1[31:0];
            unit1.unit_number = nf_count;
            unit1.unit_time   = time_new;
        end else begin
            unit1.unit_start  = 32'd0;
            unit1.unit_length = w_size[31:0];
            unit1.unit_number = 32'd0;
            unit1.unit_time   = 48'd0;
        end
        unit1.final_unit      = 1'b1;
        unit1.length_overflow = ovf_now;

        advance    = r_in_valid && (n_results <= i_free);
        o_in_ready = !r_in_valid || advance;

        o_push.count  = advance ? n_results : 2'd0;
        o_push.first  = emit0 ? unit0 : unit1;
        o_push.second = unit1;

        if (r_last) begin
            n_recent    = 24'd0;
            n_pos       = '0;
            n_open      = 1'b0;
            n_start     = '0;
            n_pfx_seen  = 1'b0;
            n_pfx_start = '0;
            n_count     = 32'd0;
            n_ovf       = 1'b0;
        end else begin
            n_recent = {r_recent[15:0], r_byte};
            n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + OFFSET_BITS'(1);
            n_open   = nf_open;
            n_start  = nf_start;
            n_count  = nf_count;
            n_ovf    = ovf_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_recent    <= 24'd0;
            r_pos       <= '0;
            r_open      <= 1'b0;
            r_start     <= '0;
            r_pfx_seen  <= 1'b0;
            r_pfx_start <= '0;
            r_count     <= 32'd0;
            r_ovf       <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_byte     <= i_byte_value;
                r_last     <= i_end_of_stream;
            end
            if (advance) begin
                r_recent    <= n_recent;
                r_pos       <= n_pos;
                r_open      <= n_open;
                r_start     <= n_start;
                r_pfx_seen  <= n_pfx_seen;
                r_pfx_start <= n_pfx_start;
                r_count     <= n_count;
                r_ovf       <= n_ovf;
            end
        end
    end

endmodule

>>> rtl/mvfs_outq.sv
// Two-entry result queue; takes up to two beats per cycle, gives one while the receiver is ready.
module mvfs_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mvfs_pkg::t_push  i_push,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output mvfs_pkg::t_unit  o_unit,
    output logic [1:0]       o_free
);

    mvfs_pkg::t_unit r_q [mvfs_pkg::QUEUE_DEPTH];
    mvfs_pkg::t_unit n_q [mvfs_pkg::QUEUE_DEPTH];
    logic [1:0]      r_cnt, n_cnt;
    logic            pop;
    logic [1:0]      base;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_unit      = r_q[0];
    assign pop         = o_out_valid && i_out_ready;
    // A slot freed by this cycle's pop counts as free.
    assign o_free      = 2'(mvfs_pkg::QUEUE_DEPTH) - r_cnt + {1'b0, pop};

    always_comb begin
        base  = r_cnt - {1'b0, pop};
        n_cnt = base + i_push.count;
        n_q   = r_q;
        if (pop) begin
            n_q[0] = r_q[1];
        end
        for (int j = 0; j < mvfs_pkg::QUEUE_DEPTH; j++) begin
            if (i_push.count != 2'd0 && base == 2'(j)) begin
                n_q[j] = i_push.first;
            end
            if (i_push.count == 2'd2 && base + 2'd1 == 2'(j)) begin
                n_q[j] = i_push.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_q   <= n_q;
        end
    end

endmodule

>>> rtl/mpeg_video_frame_splitter.sv
// An accepted byte passes the input register, then the result queue, to the output.
// Throughput: one byte per cycle while queue has room (scan: one registered pass).
// A beat that yields two results waits until both fit in the two-entry result queue.
// Reset (synchronous, active low) clears scan state and queue; the frame period
// register returns to 3003 ticks. Scan state also returns to reset after the last byte.
module mpeg_video_frame_splitter #(
    parameter int OFFSET_BITS = mvfs_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_unit_start,
    output logic [31:0] o_unit_length,
    output logic [31:0] o_unit_number,
    output logic [47:0] o_unit_time,
    output logic        o_final_unit,
    output logic        o_length_overflow
);

    logic [15:0]     r_period;
    logic [1:0]      free;
    mvfs_pkg::t_push push;
    mvfs_pkg::t_unit unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= mvfs_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data;
        end
    end

    mvfs_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_byte_value    (i_byte_value),
        .i_end_of_stream (i_end_of_stream),
        .i_period        (r_period),
        .i_free          (free),
        .o_push          (push)
    );

    mvfs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_unit      (unit),
        .o_free      (free)
    );

    assign o_unit_start      = unit.unit_start;
    assign o_unit_length     = unit.unit_length;
    assign o_unit_number     = unit.unit_number;
    assign o_unit_time       = unit.unit_time;
    assign o_final_unit      = unit.final_unit;
    assign o_length_overflow = unit.length_overflow;

endmodule

>>> tb/mvfs_tb_pkg.sv
// Frame unit predictor and result scoreboard for the MPEG video frame splitter bench.
package mvfs_tb_pkg;

    class frame_unit_board;
        logic [15:0] period;
        logic [23:0] recent;
        logic [31:0] pos;
        logic        frame_open;
        logic [31:0] frame_start;
        logic        prefix_seen;
        logic [31:0] prefix_start;
        logic [31:0] frame_count;
        logic        overflow;
        mvfs_pkg::t_unit units_due[$];
        int unsigned errors;
        int unsigned shown;

        function new();
            period = mvfs_pkg::PERIOD_RESET;
            errors = 0;
            shown  = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            recent       = '0;
            pos          = '0;
            frame_open   = 1'b0;
            frame_start  = '0;
            prefix_seen  = 1'b0;
            prefix_start = '0;
            frame_count  = '0;
            overflow     = 1'b0;
        endfunction

        function void set_period(logic [15:0] value);
            period = value;
        endfunction

        function int pending();
            return units_due.size();
        endfunction

        function logic [47:0] ticks();
            return {16'd0, frame_count} * {32'd0, period};
        endfunction

        function void push_unit(logic [31:0] off, logic [31:0] len, logic [31:0] num,
                                logic [47:0] tm, logic fin);
            mvfs_pkg::t_unit u;
            u.unit_start      = off;
            u.unit_length     = len;
            u.unit_number     = num;
            u.unit_time       = tm;
            u.final_unit      = fin;
            u.length_overflow = overflow;
            units_due.insert(units_due.size(), u);
        endfunction

        // Predict the units caused by one accepted byte beat.
        function void take_byte(logic [7:0] b, logic last);
            logic [31:0] at_pos;
            logic [31:0] code_at;
            logic [31:0] start_next;
            logic [31:0] size;
            int          made;
            at_pos = pos;
            made   = 0;
            if (at_pos == 32'hFFFF_FFFF) begin
                overflow = 1'b1;
            end
            if (at_pos >= 32'd3 && recent == mvfs_pkg::START_PREFIX) begin
                code_at = at_pos - 32'd3;
                if (b == mvfs_pkg::CODE_PICTURE) begin
                    start_next = prefix_seen ? prefix_start : code_at;
                    // a zero-length closure emits nothing
                    if (frame_open && start_next > frame_start) begin
                        push_unit(frame_start, start_next - frame_start, frame_count,
                                  ticks(), 1'b0);
                        made++;
                        frame_count++;
                    end
                    frame_start = start_next;
                    frame_open  = 1'b1;
                    prefix_seen = 1'b0;
                end else if ((b == mvfs_pkg::CODE_USER || b == mvfs_pkg::CODE_SEQ ||
                              b == mvfs_pkg::CODE_EXT || b == mvfs_pkg::CODE_GOP) &&
                             !prefix_seen) begin
                    prefix_seen  = 1'b1;
                    prefix_start = code_at;
                end
            end
            if (last) begin
                size = (at_pos == 32'hFFFF_FFFF) ? at_pos : at_pos + 32'd1;
                if (frame_open && frame_start < size) begin
                    push_unit(frame_start, size - frame_start, frame_count, ticks(), 1'b1);
                end else if (made == 0 && frame_count == 0) begin
                    // no picture seen: whole stream goes out as one unit
                    push_unit(32'd0, size, 32'd0, 48'd0, 1'b1);
                end
                clear_stream();
                return;
            end
            recent = {recent[15:0], b};
            if (at_pos != 32'hFFFF_FFFF) begin
                pos = at_pos + 32'd1;
            end
        endfunction

        function void match_unit(mvfs_pkg::t_unit got);
            mvfs_pkg::t_unit want;
            if (units_due.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected unit: off=%0d len=%0d num=%0d tm=%0d fin=%0b ovf=%0b",
                             got.unit_start, got.unit_length, got.unit_number,
                             got.unit_time, got.final_unit, got.length_overflow);
                end
                return;
            end
            want = units_due.pop_front();
            if (got.unit_start !== want.unit_start || got.unit_length !== want.unit_length ||
                got.unit_number !== want.unit_number || got.unit_time !== want.unit_time ||
                got.final_unit !== want.final_unit ||
                got.length_overflow !== want.length_overflow) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unit mismatch: exp off=%0d len=%0d num=%0d tm=%0d fin=%0b ovf=%0b",
                             want.unit_start, want.unit_length, want.unit_number,
                             want.unit_time, want.final_unit, want.length_overflow);
                    $display("               got off=%0d len=%0d num=%0d tm=%0d fin=%0b ovf=%0b",
                             got.unit_start, got.unit_length, got.unit_number,
                             got.unit_time, got.final_unit, got.length_overflow);
                end
            end
        endfunction

        function void close_run();
            if (units_due.size() != 0) begin
                errors++;
                $display("%0d expected units never arrived", units_due.size());
            end
        endfunction
    endclass

endpackage

>>> tb/tb_top.sv
// Top-level bench: drives byte streams into the frame splitter and checks every unit beat.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_AFTER   = 390;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [15:0] i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_value    = '0;
    logic        i_end_of_stream = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [31:0] o_unit_start;
    logic [31:0] o_unit_length;
    logic [31:0] o_unit_number;
    logic [47:0] o_unit_time;
    logic        o_final_unit;
    logic        o_length_overflow;

    mvfs_tb_pkg::frame_unit_board board = new();

    logic [7:0] stream_bytes[$];
    int         rand_items   = 0;
    bit         calm         = 1'b0;
    bit         tx_jitter    = 1'b0;
    bit         rx_jitter    = 1'b0;
    bit         pressure_req = 1'b0;

    mpeg_video_frame_splitter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_value     (i_byte_value),
        .i_end_of_stream  (i_end_of_stream),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_unit_start     (o_unit_start),
        .o_unit_length    (o_unit_length),
        .o_unit_number    (o_unit_number),
        .o_unit_time      (o_unit_time),
        .o_final_unit     (o_final_unit),
        .o_length_overflow(o_length_overflow)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("[mpeg_video_frame_splitter] ERROR");
        $finish;
    end

    // result beat monitor
    always @(posedge i_clk) begin
        mvfs_pkg::t_unit got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            got.unit_start      = o_unit_start;
            got.unit_length     = o_unit_length;
            got.unit_number     = o_unit_number;
            got.unit_time       = o_unit_time;
            got.final_unit      = o_final_unit;
            got.length_overflow = o_length_overflow;
            board.match_unit(got);
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (90) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (rx_jitter && !calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Called just after the clock rises; returns once the splitter has accepted the byte.
    task automatic send_byte(logic [7:0] b, logic last);
        i_in_valid      <= 1'b1;
        i_byte_value    <= b;
        i_end_of_stream <= last;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        board.take_byte(b, last);
    endtask

    task automatic send_stream(bit counted);
        for (int i = 0; i < stream_bytes.size(); i++) begin
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
            if (counted) begin
                rand_items++;
                if (rand_items >= CALM_AFTER) calm = 1'b1;
            end
            if (tx_jitter && !calm && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid and wait until every predicted unit has been seen.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_period(logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_period(value);
    endtask

    task automatic add_byte(logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endtask

    task automatic add_code(logic [7:0] code);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h01);
        add_byte(code);
    endtask

    task automatic build_well_formed();
        int target;
        int pick;
        logic [7:0] code;
        stream_bytes.delete();
        target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : $urandom_range(8, 48);
        while (stream_bytes.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: code = mvfs_pkg::CODE_PICTURE;
                    4:          code = mvfs_pkg::CODE_USER;
                    5:          code = mvfs_pkg::CODE_SEQ;
                    6:          code = mvfs_pkg::CODE_EXT;
                    7:          code = mvfs_pkg::CODE_GOP;
                    8:          code = 8'($urandom_range(0, 255));
                    default:    code = 8'h01;
                endcase
                add_code(code);
            end else if (pick == 9) begin
                // broken prefix: zeros with no 01
                repeat ($urandom_range(1, 3)) add_byte(8'h00);
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    add_byte(($urandom_range(0, 3) == 0) ? 8'h00
                             : 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic build_noise();
        int pick;
        stream_bytes.delete();
        repeat ($urandom_range(1, 40)) begin
            pick = $urandom_range(0, 5);
            add_byte((pick < 2) ? 8'h00 : (pick == 2) ? 8'h01
                     : 8'($urandom_range(0, 255)));
        end
    endtask

    // dense picture codes so results pile up behind a stalled receiver
    task automatic build_pressure();
        stream_bytes.delete();
        repeat (20) begin
            add_code(mvfs_pkg::CODE_PICTURE);
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(2, 255)));
        end
    endtask

    initial begin
        int stream_idx;
        int cfg_round;
        logic [15:0] next_period;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte stream with no picture, then a stream with a two-byte
        // lead-in that must not form a prefix, a GOP header, an ignored second
        // header, a picture, an extension header and a picture on the last byte.
        stream_bytes.delete();
        add_byte(8'hFF);
        send_stream(1'b0);
        stream_bytes.delete();
        add_byte(8'h00);
        add_byte(8'h01);
        add_byte(mvfs_pkg::CODE_SEQ);
        add_code(mvfs_pkg::CODE_GOP);
        add_code(mvfs_pkg::CODE_USER);
        add_code(mvfs_pkg::CODE_PICTURE);
        add_code(mvfs_pkg::CODE_EXT);
        add_code(mvfs_pkg::CODE_PICTURE);
        send_stream(1'b0);
        settle();

        stream_idx = 0;
        cfg_round  = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if (stream_idx % 5 == 4) begin
                settle();
                case (cfg_round % 4)
                    0:       next_period = 16'h0000;
                    1:       next_period = 16'hFFFF;
                    2:       next_period = 16'd1;
                    default: next_period = 16'($urandom_range(0, 65535));
                endcase
                write_period(next_period);
                cfg_round++;
            end
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            if (stream_idx == 3) begin
                build_pressure();
                tx_jitter    = 1'b0;
                pressure_req = 1'b1;
            end else if ($urandom_range(0, 6) == 0) begin
                build_noise();
            end else begin
                build_well_formed();
            end
            send_stream(1'b1);
            stream_idx++;
        end

        settle();
        board.close_run();
        if (board.errors == 0) begin
            $display("[mpeg_video_frame_splitter] OK");
        end else begin
            $display("[mpeg_video_frame_splitter] ERROR");
        end
        $finish;
    end

endmodule
